FILE: hdl/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types for the WebSocket frame receiver: result codes, one result
// and the group of results that one received byte produces.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  // Most results that a single received byte can produce (pong header)
  localparam int unsigned MaxResults = 6;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  // What a result carries
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic        msg_last;
  } result_t;

  // All results caused by one received byte, first result in res[0]
  typedef struct packed {
    logic [CountW-1:0]               count;
    result_t [MaxResults-1:0]        res;
  } burst_t;

endpackage

FILE: hdl/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// WebSocket deframer: received bytes in, payload bytes, reply bytes and
// link events out.
// ----------------------------------------------------------------------------
// One received byte enters per cycle, while the holding register is empty or
// empties, into a holding register and is parsed in a single pass; its results
// (none to six) are then sent one item per cycle, while out_tready is high, from
// the result register. A byte that gives at most one result therefore lets
// payload stream at one byte per cycle with out_tready high. A byte that
// completes a ping header gives six reply items and one that ends a close frame
// gives three items; such a byte occupies the output until all its items are
// sent, while the next byte already waits in the holding register. After a close
// frame every further byte is taken and dropped. The mask key register (cfg port,
// reset 0x12345678) applies its most significant byte to pong payload byte zero.
module websocket_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] value, [8] message_last, zero above
  output logic [1:0]  out_tuser,   // [1:0] kind
  output logic        out_tlast,   // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data     // mask_key
);

  wsfr_pkg::burst_t burst;
  logic             burst_load;
  logic             burst_free;

  // Parse bytes into result groups
  wsfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .burst_free (burst_free),
    .burst_load (burst_load),
    .burst      (burst)
  );

  // Send results one item at a time
  wsfr_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst_load (burst_load),
    .burst      (burst),
    .burst_free (burst_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hdl/wsfr_parser.sv
// ----------------------------------------------------------------------------
// wsfr_parser
// Input holding register, frame parsing state and the mask key register.
// Each held byte is parsed in one pass and turns into a group of results.
// ----------------------------------------------------------------------------
module wsfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  input  logic                burst_free,
  output logic                burst_load,
  output wsfr_pkg::burst_t    burst
);

  typedef enum logic [3:0] {
    PH_HDR0 = 4'b0001,
    PH_HDR1 = 4'b0010,
    PH_EXT  = 4'b0100,
    PH_PAY  = 4'b1000
  } phase_t;

  localparam logic [3:0]  OpText     = 4'h1;
  localparam logic [3:0]  OpBinary   = 4'h2;
  localparam logic [3:0]  OpClose    = 4'h8;
  localparam logic [3:0]  OpPing     = 4'h9;
  localparam logic [6:0]  LenCode16  = 7'd126;
  localparam logic [6:0]  LenCode64  = 7'd127;
  localparam logic [3:0]  ExtBytes16 = 4'd2;
  localparam logic [3:0]  ExtBytes64 = 4'd8;
  localparam logic [7:0]  PongHdr    = 8'h8A;
  localparam logic [7:0]  CloseHdr   = 8'h88;
  localparam logic [7:0]  CloseLen   = 8'h00;
  localparam logic [7:0]  MaskFlag   = 8'h80;
  localparam logic [31:0] KeyReset   = 32'h1234_5678;

  // Key byte at a mask position, most significant byte first
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
    logic [7:0] kb;
    case (pos)
      2'd0:    kb = key[31:24];
      2'd1:    kb = key[23:16];
      2'd2:    kb = key[15:8];
      default: kb = key[7:0];
    endcase
    return kb;
  endfunction

  function automatic wsfr_pkg::result_t mk(input wsfr_pkg::kind_t k, input logic [7:0] v,
                                             input logic ml);
    wsfr_pkg::result_t r;
    r.kind     = k;
    r.value    = v;
    r.msg_last = ml;
    return r;
  endfunction

  logic        hold_valid_r, hold_valid_nxt;
  logic [7:0]  hold_byte_r;
  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [3:0]  lbl_r, lbl_nxt;
  logic [1:0]  mpos_r, mpos_nxt;
  logic        closed_r, closed_nxt;
  logic [31:0] key_r;
  logic        consume;
  wsfr_pkg::burst_t burst_c;

  // Take a new byte whenever the holding register is empty or empties this cycle
  assign consume    = hold_valid_r && burst_free;
  assign in_tready  = !hold_valid_r || burst_free;
  assign cfg_ready  = 1'b1;
  assign burst_load = consume;
  assign burst      = burst_c;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (consume) begin
      hold_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      hold_valid_nxt = 1'b1;
    end
  end

  // Parse the held byte
  always_comb begin
    logic [63:0] len_v;
    logic [63:0] rem_dec;
    logic [3:0]  lbl_dec;
    logic        start;
    logic        empty;
    logic        last;
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    rem_nxt    = rem_r;
    lbl_nxt    = lbl_r;
    mpos_nxt   = mpos_r;
    closed_nxt = closed_r;
    burst_c    = '0;
    len_v      = rem_r;
    rem_dec    = rem_r - 64'd1;
    lbl_dec    = lbl_r;
    start      = 1'b0;
    empty      = 1'b0;
    last       = 1'b0;

    if (!closed_r) begin
      case (phase_r)
        PH_HDR1: begin
          rem_nxt = '0;
          if (hold_byte_r[6:0] == LenCode16) begin
            lbl_nxt   = ExtBytes16;
            phase_nxt = PH_EXT;
          end else if (hold_byte_r[6:0] == LenCode64) begin
            lbl_nxt   = ExtBytes64;
            phase_nxt = PH_EXT;
          end else begin
            lbl_nxt = '0;
            len_v   = {57'd0, hold_byte_r[6:0]};
            rem_nxt = len_v;
            start   = 1'b1;
          end
        end
        PH_EXT: begin
          len_v   = {rem_r[55:0], hold_byte_r};
          rem_nxt = len_v;
          if (lbl_r != 4'd0) begin
            lbl_dec = lbl_r - 4'd1;
          end
          lbl_nxt = lbl_dec;
          if (lbl_dec == 4'd0) begin
            start = 1'b1;
          end
        end
        PH_PAY: begin
          if (rem_r == 64'd0) begin
            phase_nxt = PH_HDR0;
          end else begin
            rem_nxt = rem_dec;
            last    = (rem_dec == 64'd0);
            case (opcode_r)
              OpText, OpBinary: begin
                burst_c.res[0] = mk(wsfr_pkg::KIND_DATA, hold_byte_r, last);
                burst_c.count  = wsfr_pkg::CountW'(1);
              end
              OpPing: begin
                burst_c.res[0] = mk(wsfr_pkg::KIND_REPLY,
                                    hold_byte_r ^ key_byte(key_r, mpos_r), last);
                burst_c.count  = wsfr_pkg::CountW'(1);
                mpos_nxt       = mpos_r + 2'd1;
              end
              default: begin
              end
            endcase
            if (last) begin
              phase_nxt = PH_HDR0;
              // Close frame done: answer and shut the link
              if (opcode_r == OpClose) begin
                burst_c.res[0] = mk(wsfr_pkg::KIND_REPLY, CloseHdr, 1'b0);
                burst_c.res[1] = mk(wsfr_pkg::KIND_REPLY, CloseLen, 1'b1);
                burst_c.res[2] = mk(wsfr_pkg::KIND_CLOSE, 8'h00, 1'b0);
                burst_c.count  = wsfr_pkg::CountW'(3);
                closed_nxt     = 1'b1;
              end
            end
          end
        end
        default: begin
          opcode_nxt = hold_byte_r[3:0];
          phase_nxt  = PH_HDR1;
        end
      endcase
    end

    // Length complete: open the payload or finish an empty frame
    if (start) begin
      empty     = (len_v == 64'd0);
      mpos_nxt  = 2'd0;
      phase_nxt = empty ? PH_HDR0 : PH_PAY;
      case (opcode_r)
        OpText, OpBinary: begin
          if (empty) begin
            burst_c.res[0] = mk(wsfr_pkg::KIND_EMPTY, 8'h00, 1'b0);
            burst_c.count  = wsfr_pkg::CountW'(1);
          end
        end
        OpPing: begin
          burst_c.res[0] = mk(wsfr_pkg::KIND_REPLY, PongHdr, 1'b0);
          burst_c.res[1] = mk(wsfr_pkg::KIND_REPLY, MaskFlag | {1'b0, len_v[6:0]}, 1'b0);
          burst_c.res[2] = mk(wsfr_pkg::KIND_REPLY, key_byte(key_r, 2'd0), 1'b0);
          burst_c.res[3] = mk(wsfr_pkg::KIND_REPLY, key_byte(key_r, 2'd1), 1'b0);
          burst_c.res[4] = mk(wsfr_pkg::KIND_REPLY, key_byte(key_r, 2'd2), 1'b0);
          burst_c.res[5] = mk(wsfr_pkg::KIND_REPLY, key_byte(key_r, 2'd3), empty);
          burst_c.count  = wsfr_pkg::CountW'(6);
        end
        OpClose: begin
          if (empty) begin
            burst_c.res[0] = mk(wsfr_pkg::KIND_REPLY, CloseHdr, 1'b0);
            burst_c.res[1] = mk(wsfr_pkg::KIND_REPLY, CloseLen, 1'b1);
            burst_c.res[2] = mk(wsfr_pkg::KIND_CLOSE, 8'h00, 1'b0);
            burst_c.count  = wsfr_pkg::CountW'(3);
            closed_nxt     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the incoming byte
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_byte_r <= in_tdata;
    end
  end

  // Advance the parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      phase_r      <= PH_HDR0;
      opcode_r     <= '0;
      rem_r        <= '0;
      lbl_r        <= '0;
      mpos_r       <= '0;
      closed_r     <= 1'b0;
      key_r        <= KeyReset;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (consume) begin
        phase_r  <= phase_nxt;
        opcode_r <= opcode_nxt;
        rem_r    <= rem_nxt;
        lbl_r    <= lbl_nxt;
        mpos_r   <= mpos_nxt;
        closed_r <= closed_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        key_r <= cfg_data;
      end
    end
  end

endmodule

FILE: hdl/wsfr_emitter.sv
// ----------------------------------------------------------------------------
// wsfr_emitter
// Result register: holds the results of one byte and sends them out one
// item per cycle while out_tready is high, marking the final one of the group.
// ----------------------------------------------------------------------------
module wsfr_emitter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                burst_load,
  input  wsfr_pkg::burst_t    burst,
  output logic                burst_free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,   // [7:0] value, [8] message_last, zero above
  output logic [1:0]          out_tuser,   // [1:0] kind
  output logic                out_tlast
);

  wsfr_pkg::result_t [wsfr_pkg::MaxResults-1:0] res_r;
  logic [wsfr_pkg::CountW-1:0] left_r, left_nxt;
  logic [wsfr_pkg::CountW-1:0] idx_r, idx_nxt;
  wsfr_pkg::result_t cur;
  logic take;
  logic on_last;

  assign cur        = res_r[idx_r];
  assign on_last    = (left_r == wsfr_pkg::CountW'(1));
  assign out_tvalid = (left_r != '0);
  assign take       = out_tvalid && out_tready;
  assign burst_free = (left_r == '0) || (take && on_last);
  assign out_tdata  = {7'd0, cur.msg_last, cur.value};
  assign out_tuser  = cur.kind;
  assign out_tlast  = on_last;

  // Load a new group or step to the next result
  always_comb begin
    left_nxt = left_r;
    idx_nxt  = idx_r;
    if (burst_load) begin
      left_nxt = burst.count;
      idx_nxt  = '0;
    end else if (take) begin
      left_nxt = left_r - wsfr_pkg::CountW'(1);
      idx_nxt  = idx_r + wsfr_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      res_r <= burst.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      idx_r  <= '0;
    end else begin
      left_r <= left_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule
